// File: hw/rtl/rwbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwbc_pkg
// Types and constants shared by the register write burst coalescer.
// ----------------------------------------------------------------------------
package rwbc_pkg;

    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 3;
    localparam int BYTE_SLOTS = 7;
    localparam int MAX_BURST  = 7;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 80;
    localparam int M_USED_W   = ADDR_W + COUNT_W + BYTE_SLOTS * BYTE_W;

    typedef struct packed {
        logic                                 last;
        logic [BYTE_SLOTS-1:0][BYTE_W-1:0]    data;
        logic [COUNT_W-1:0]                   count;
        logic [ADDR_W-1:0]                    start;
    } burst_t;

    typedef struct packed {
        logic [1:0] num;
        burst_t     first;
        burst_t     second;
    } push_t;

endpackage
`default_nettype wire

// File: hw/rtl/rwbc_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwbc_merge
// Open burst state; merges one write per cycle while in_accept is high and emits up to two bursts.
// ----------------------------------------------------------------------------
module rwbc_merge
    import rwbc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_accept,
    input  wire logic [ADDR_W-1:0] in_address,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_last,
    output push_t                  push
);

    logic [ADDR_W-1:0]                  open_start_reg;
    logic [ADDR_W-1:0]                  open_start_next;
    logic [COUNT_W-1:0]                 open_count_reg;
    logic [COUNT_W-1:0]                 open_count_next;
    logic [BYTE_SLOTS-1:0][BYTE_W-1:0]  open_bytes_reg;
    logic [BYTE_SLOTS-1:0][BYTE_W-1:0]  open_bytes_next;

    logic               have_open;
    logic               append;
    logic [ADDR_W:0]    expect_addr;
    logic [COUNT_W-1:0] placed_count;
    burst_t             emit_open;
    burst_t             emit_placed;

    always_comb begin
        have_open   = (open_count_reg != '0);
        expect_addr = {1'b0, open_start_reg} + (ADDR_W + 1)'(open_count_reg);
        append      = have_open && ({1'b0, in_address} == expect_addr)
                      && (open_count_reg < COUNT_W'(MAX_BURST));

        placed_count    = append ? open_count_reg + COUNT_W'(1) : COUNT_W'(1);
        open_start_next = append ? open_start_reg : in_address;
        open_bytes_next = open_bytes_reg;
        for (int k = 0; k < BYTE_SLOTS; k++) begin
            if ((append && (COUNT_W'(k) == open_count_reg)) || (!append && (k == 0))) begin
                open_bytes_next[k] = in_byte;
            end
        end
        open_count_next = in_last ? '0 : placed_count;
    end

    always_comb begin
        emit_open.start   = open_start_reg;
        emit_open.count   = open_count_reg;
        emit_open.last    = 1'b0;
        emit_placed.start = open_start_next;
        emit_placed.count = placed_count;
        emit_placed.last  = 1'b1;
        for (int k = 0; k < BYTE_SLOTS; k++) begin
            emit_open.data[k]   = (COUNT_W'(k) < open_count_reg) ? open_bytes_reg[k] : '0;
            emit_placed.data[k] = (COUNT_W'(k) < placed_count) ? open_bytes_next[k] : '0;
        end
    end

    always_comb begin
        push.num    = 2'd0;
        push.first  = emit_open;
        push.second = emit_placed;
        if (in_accept) begin
            if (have_open && !append) begin
                push.num = in_last ? 2'd2 : 2'd1;
            end else if (in_last) begin
                push.num   = 2'd1;
                push.first = emit_placed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_start_reg <= '0;
            open_count_reg <= '0;
        end else if (in_accept) begin
            open_start_reg <= open_start_next;
            open_count_reg <= open_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            open_bytes_reg <= open_bytes_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/rwbc_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwbc_fifo
// Result queue taking up to two bursts per cycle and releasing one on each pop.
// ----------------------------------------------------------------------------
module rwbc_fifo
    import rwbc_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire push_t                             push,
    input  wire logic                              pop,
    output burst_t                                 head,
    output logic                                   not_empty,
    output logic                                   room_for_two,
    output logic [$clog2(FIFO_DEPTH + 1)-1:0]      level
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    burst_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [LVL_W-1:0]   level_reg;
    logic [LVL_W-1:0]   level_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        wr_ptr_plus1 = ptr_inc(wr_ptr_reg);
        case (push.num)
            2'd1:    wr_ptr_next = wr_ptr_plus1;
            2'd2:    wr_ptr_next = ptr_inc(wr_ptr_plus1);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        level_next  = level_reg + LVL_W'(push.num) - LVL_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.num != 2'd0) begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.num == 2'd2) begin
            mem[wr_ptr_plus1] <= push.second;
        end
    end

    assign head         = mem[rd_ptr_reg];
    assign not_empty    = (level_reg != '0);
    assign room_for_two = (level_reg <= LVL_W'(FIFO_DEPTH - 2));
    assign level        = level_reg;

endmodule
`default_nettype wire

// File: hw/rtl/register_write_burst_coalescer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// register_write_burst_coalescer
// Merges single-byte register writes at consecutive addresses into bursts.
// ----------------------------------------------------------------------------
// Usage:
//   s_ carries one register write per transaction: address and data byte in
//   s_tdata, s_tlast on the final entry of the write table.
//   m_ carries one burst per transaction: start address, byte count and up to
//   seven data bytes in m_tdata (bytes past the count are zero), m_tlast on
//   the burst flushed by the final table entry.
//   A write is merged in the cycle it is accepted; any burst it closes is
//   queued for m_ behind earlier bursts. One write is accepted every cycle
//   while the result queue has room for two bursts, so the block sustains one
//   write per cycle; a write that both closes a burst and ends the table
//   queues two bursts, which drain at one per cycle while m_tready is high.
//   The queue depth FIFO_DEPTH sets how long m_tready may stay low before
//   s_tready drops. Reset empties the queue and closes the open burst; no
//   startup sweep is needed. While m_tready is low the head burst holds.
// ----------------------------------------------------------------------------
module register_write_burst_coalescer
    import rwbc_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // write_address, write_byte
    input  wire logic                  s_tlast,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // burst_start, burst_count, byte_0..byte_6
    output logic                       m_tlast
);

    localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

    logic               s_accept;
    logic               m_accept;
    push_t              push;
    burst_t             head;
    logic               not_empty;
    logic               room_for_two;
    logic [LVL_W-1:0]   level;

    assign s_accept = s_tvalid && s_tready;
    assign m_accept = m_tvalid && m_tready;

    rwbc_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (s_accept),
        .in_address (s_tdata[ADDR_W-1:0]),
        .in_byte    (s_tdata[ADDR_W +: BYTE_W]),
        .in_last    (s_tlast),
        .push       (push)
    );

    rwbc_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push         (push),
        .pop          (m_accept),
        .head         (head),
        .not_empty    (not_empty),
        .room_for_two (room_for_two),
        .level        (level)
    );

    assign s_tready = room_for_two;
    assign m_tvalid = not_empty;
    assign m_tlast  = head.last;
    assign m_tdata  = {(M_TDATA_W - M_USED_W)'(0), head.data, head.count, head.start};

`ifndef SYNTH
    assert property (@(posedge aclk) disable iff (!aresetn)
        level <= LVL_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push.num != 2'd3)
        else $error("invalid burst push count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push.num == 2'd2 |-> !push.first.last && push.second.last)
        else $error("two bursts pushed without closing the table");

    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_tlast |-> push.num != 2'd0)
        else $error("table end did not flush a burst");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push.num != 2'd0 |-> push.first.count != '0)
        else $error("empty burst pushed");
`endif

endmodule
`default_nettype wire
